/* sv/lpnc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpnc_pkg
// types, stage numbering and arithmetic helpers for the point covariance core
// ----------------------------------------------------------------------------
package lpnc_pkg;

  // configuration register indexes
  localparam logic REG_RANGE_NOISE      = 1'b0;
  localparam logic REG_ANGLE_NOISE_SINE = 1'b1;

  localparam logic [15:0] RANGE_NOISE_RESET      = 16'd1311;
  localparam logic [15:0] ANGLE_NOISE_SINE_RESET = 16'd175;

  // 1e-6 in q.30
  localparam logic signed [31:0] DZ_FLOOR = 32'sd1074;
  localparam logic [31:0]        ONE_Q30  = 32'd1073741824;

  // square roots and divisions resolve two bits per stage
  localparam int ROOT_W = 32;
  localparam int ITER   = ROOT_W / 2;

  // stage numbering, stage 0 is the input register
  localparam int ST_SQ    = 1;
  localparam int ST_R2    = ST_SQ + 1;
  localparam int SQ1      = ST_R2 + 1;
  localparam int DV1_SET  = SQ1 + ITER;
  localparam int DV1      = DV1_SET + 1;
  localparam int D_OUT    = DV1 + ITER;
  localparam int N1_SQ    = D_OUT + 1;
  localparam int N1_SUM   = N1_SQ + 1;
  localparam int SQ2      = N1_SUM + 1;
  localparam int DV2_SET  = SQ2 + ITER;
  localparam int DV2      = DV2_SET + 1;
  localparam int B1_OUT   = DV2 + ITER;
  localparam int X1_MUL   = B1_OUT + 1;
  localparam int X1_RND   = X1_MUL + 1;
  localparam int C2_SQ    = X1_RND + 1;
  localparam int N2_SUM   = C2_SQ + 1;
  localparam int SQ3      = N2_SUM + 1;
  localparam int DV3_SET  = SQ3 + ITER;
  localparam int DV3      = DV3_SET + 1;
  localparam int B2_OUT   = DV3 + ITER;
  localparam int X2_MUL   = B2_OUT + 1;
  localparam int X2_RND   = X2_MUL + 1;
  localparam int E_MUL    = X2_RND + 1;
  localparam int E_RND    = E_MUL + 1;
  localparam int E_PP     = E_RND + 1;
  localparam int E_SUM    = E_PP + 1;
  localparam int E_T2     = E_SUM + 1;
  localparam int E_OUT    = E_T2 + 1;
  localparam int NUM_STAGES = E_OUT + 1;

  // row and column of each unique covariance entry
  localparam int PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J [6] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] q;
  } div_t;

  // everything an item carries down the pipeline
  typedef struct packed {
    logic [2:0][23:0]      p;
    logic [2:0][46:0]      sq;
    logic [47:0]           r2;
    logic                  zero;
    logic [55:0]           rs_lo;
    logic [55:0]           rs_hi;
    logic [79:0]           rs;
    logic [63:0]           sx;
    logic [33:0]           srem;
    logic [31:0]           sroot;
    logic [31:0]           den;
    logic [2:0][31:0]      dn;
    logic [2:0][31:0]      drem;
    logic [2:0][31:0]      dq;
    logic [2:0][31:0]      d;
    logic [31:0]           dzc;
    logic [32:0]           sxy;
    logic [61:0]           dzsq;
    logic [63:0]           sxsq;
    logic [2:0][31:0]      b1;
    logic [5:0][63:0]      xp;
    logic [2:0][32:0]      c2;
    logic [2:0][63:0]      csq;
    logic                  n2zero;
    logic [2:0][31:0]      b2;
    logic [2:0][32:0]      v;
    logic [5:0][63:0]      pdd;
    logic [5:0][63:0]      puu;
    logic [5:0][63:0]      pvv;
    logic [5:0][32:0]      ddr;
    logic [5:0][33:0]      wm;
    logic [5:0]            wneg;
    logic [5:0][63:0]      t1p;
    logic [5:0][2:0][60:0] pp;
    logic [5:0][22:0]      t1;
    logic [5:0][113:0]     prod;
    logic [5:0][51:0]      t2;
    logic [5:0][47:0]      cov;
  } item_t;

  // one bit of a restoring square root
  function automatic sqrt_t sqrt_step(input sqrt_t st, input logic [1:0] bits);
    sqrt_t       o;
    logic [35:0] t;
    logic [35:0] trial;
    t     = {st.rem, bits};
    trial = {2'b00, st.root, 2'b01};
    if (t >= trial) begin
      o.rem  = 34'(t - trial);
      o.root = {st.root[30:0], 1'b1};
    end else begin
      o.rem  = t[33:0];
      o.root = {st.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // one bit of a restoring division
  function automatic div_t div_step(input div_t st, input logic [31:0] den,
                                    input logic nbit);
    div_t        o;
    logic [32:0] t;
    t = {st.rem, nbit};
    if (t >= {1'b0, den}) begin
      o.rem = 32'(t - {1'b0, den});
      o.q   = {st.q[30:0], 1'b1};
    end else begin
      o.rem = t[31:0];
      o.q   = {st.q[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    logic [63:0] m;
    m = a[63] ? 64'(-a) : 64'(a);
    return m;
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] a);
    logic [32:0] m;
    m = a[32] ? 33'(-a) : 33'(a);
    return m[31:0];
  endfunction

  function automatic logic [23:0] mag24(input logic signed [23:0] a);
    logic [23:0] m;
    m = a[23] ? 24'(-a) : 24'(a);
    return m;
  endfunction

  // shift right by 30, magnitude rounded half up, sign kept
  function automatic logic signed [34:0] rnd30(input logic signed [63:0] a);
    logic [63:0] s;
    logic [34:0] m;
    s = mag64(a) + 64'd536870912;
    m = {1'b0, s[63:30]};
    return a[63] ? 35'(-m) : m;
  endfunction

  // quotient limited to 1.0 in q.30, then signed
  function automatic logic [31:0] clamp_q30(input logic [31:0] q, input logic neg);
    logic [31:0] m;
    m = (q > ONE_Q30) ? ONE_Q30 : q;
    return neg ? 32'(-m) : m;
  endfunction

  function automatic logic signed [63:0] smul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] r;
    r = a * b;
    return r;
  endfunction

  function automatic logic signed [63:0] smul33(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
    logic signed [65:0] r;
    r = a * b;
    return r[63:0];
  endfunction

endpackage : lpnc_pkg
`default_nettype wire

/* sv/lidar_point_noise_covariance_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_point_noise_covariance_core
// measurement-noise covariance of one body-frame lidar point, six entries
// ----------------------------------------------------------------------------
//
//  channel   signals                               direction
//  --------  ------------------------------------  ---------
//  config    cfg_write, cfg_index, cfg_data        in
//  point     in_valid/in_ready, point_x/y/z        in
//  result    out_valid/out_ready, cov_xx .. cov_zz out
//
//  one request accepted per cycle while in_ready is high; its result passes
//  through 119 pipeline stages and then the output register
//  the depth is set by three square roots and three dividers in a row,
//  each resolving two bits per stage over 16 stages
//  rst clears valid bits and handshake state and reloads the two noise registers
//  a stalled output parks one result in a skid register; the pipeline
//  freezes only while that skid register is full
//
module lidar_point_noise_covariance_core (
  input  wire                logic        clk,
  input  wire                logic        rst,
  input  wire                logic        cfg_write,
  input  wire                logic        cfg_index,
  input  wire                logic [15:0] cfg_data,
  input  wire                logic        in_valid,
  output                     logic        in_ready,
  input  wire  logic signed        [23:0] point_x,
  input  wire  logic signed        [23:0] point_y,
  input  wire  logic signed        [23:0] point_z,
  output                     logic        out_valid,
  input  wire                logic        out_ready,
  output       logic signed        [47:0] cov_xx,
  output       logic signed        [47:0] cov_xy,
  output       logic signed        [47:0] cov_xz,
  output       logic signed        [47:0] cov_yy,
  output       logic signed        [47:0] cov_yz,
  output       logic signed        [47:0] cov_zz
);
  import lpnc_pkg::*;

  // configuration registers and their squares
  logic [15:0] range_noise;
  logic [15:0] angle_noise_sine;
  logic [31:0] range_sq;
  logic [31:0] angle_var;

  // pipeline
  item_t                   pipe [NUM_STAGES];
  logic [NUM_STAGES-1:0]   pipe_v;
  item_t                   in_ctx;
  logic                    en;
  logic                    tail_v;

  // output side
  logic                    out_v;
  logic                    skid_v;
  logic [5:0][47:0]        out_cov;
  logic [5:0][47:0]        skid_cov;

  // work done by each stage; s is fixed per instance so only its own
  // arm survives elaboration
  function automatic item_t stage_work(input int s, input item_t c,
                                       input logic [31:0] rv,
                                       input logic [31:0] s2);
    item_t              o;
    sqrt_t              sq;
    div_t               dv;
    logic [63:0]        num;
    logic [31:0]        mg;
    logic [31:0]        dzc;
    logic signed [34:0] w;
    logic [63:0]        t1s;
    logic [21:0]        t1m;
    logic [113:0]       tmp;
    logic [51:0]        t2m;
    logic signed [52:0] tot;
    int                 k;
    int                 e;
    o = c;

    if (s == ST_SQ) begin
      for (k = 0; k < 3; k++) begin
        o.sq[k] = 47'(smul32(32'($signed(c.p[k])), 32'($signed(c.p[k]))));
      end
    end

    // r2 exact, then set up the first root on r2 * 2^16
    if (s == ST_R2) begin
      o.r2   = 48'(c.sq[0]) + 48'(c.sq[1]) + 48'(c.sq[2]);
      o.zero = (o.r2 == '0);
      o.sx   = {o.r2, 16'b0};
      o.srem = '0;
      o.sroot = '0;
    end

    // shared square root stages
    if ((s >= SQ1 && s < SQ1 + ITER) || (s >= SQ2 && s < SQ2 + ITER) ||
        (s >= SQ3 && s < SQ3 + ITER)) begin
      sq.rem  = c.srem;
      sq.root = c.sroot;
      sq = sqrt_step(sq, c.sx[63:62]);
      sq = sqrt_step(sq, c.sx[61:60]);
      o.srem  = sq.rem;
      o.sroot = sq.root;
      o.sx    = {c.sx[59:0], 4'b0};
    end

    // r2 * sine^2 for the angle term, built alongside the first root
    if (s == SQ1) begin
      o.rs_lo = c.r2[23:0] * s2;
      o.rs_hi = c.r2[47:24] * s2;
    end
    if (s == SQ1 + 1) begin
      o.rs = {24'b0, c.rs_lo} + {c.rs_hi, 24'b0};
    end

    // numerators rounded half up: (|n| << sh) + den / 2
    if (s == DV1_SET) begin
      o.den = c.sroot;
      for (k = 0; k < 3; k++) begin
        num = ({40'b0, mag24(c.p[k])} << 38) + {33'b0, c.sroot[31:1]};
        o.drem[k] = num[63:32];
        o.dn[k]   = num[31:0];
        o.dq[k]   = '0;
      end
    end
    if (s == DV2_SET) begin
      o.den = c.sroot;
      for (k = 0; k < 3; k++) begin
        mg  = (k == 2) ? mag33(c.sxy) : c.dzc;
        num = ({32'b0, mg} << 30) + {33'b0, c.sroot[31:1]};
        o.drem[k] = num[63:32];
        o.dn[k]   = num[31:0];
        o.dq[k]   = '0;
      end
    end
    if (s == DV3_SET) begin
      o.den = c.sroot;
      for (k = 0; k < 3; k++) begin
        num = ({32'b0, mag33(c.c2[k])} << 30) + {33'b0, c.sroot[31:1]};
        o.drem[k] = num[63:32];
        o.dn[k]   = num[31:0];
        o.dq[k]   = '0;
      end
    end

    // shared division stages, three lanes over one divisor
    if ((s >= DV1 && s < DV1 + ITER) || (s >= DV2 && s < DV2 + ITER) ||
        (s >= DV3 && s < DV3 + ITER)) begin
      for (k = 0; k < 3; k++) begin
        dv.rem = c.drem[k];
        dv.q   = c.dq[k];
        dv = div_step(dv, c.den, c.dn[k][31]);
        dv = div_step(dv, c.den, c.dn[k][30]);
        o.drem[k] = dv.rem;
        o.dq[k]   = dv.q;
        o.dn[k]   = {c.dn[k][29:0], 2'b0};
      end
    end

    // unit direction
    if (s == D_OUT) begin
      for (k = 0; k < 3; k++) begin
        o.d[k] = clamp_q30(c.dq[k], c.p[k][23]);
      end
    end

    // first tangent before normalization: (g, g, -(dx+dy))
    if (s == N1_SQ) begin
      dzc   = ($signed(c.d[2]) > DZ_FLOOR) ? c.d[2] : DZ_FLOOR;
      o.dzc = dzc;
      o.sxy = {c.d[0][31], c.d[0]} + {c.d[1][31], c.d[1]};
      o.dzsq = dzc[30:0] * dzc[30:0];
      mg     = mag33(o.sxy);
      o.sxsq = mg * mg;
    end
    if (s == N1_SUM) begin
      o.sx    = {1'b0, c.dzsq, 1'b0} + c.sxsq;
      o.srem  = '0;
      o.sroot = '0;
    end

    if (s == B1_OUT) begin
      o.b1[0] = clamp_q30(c.dq[0], 1'b0);
      o.b1[1] = clamp_q30(c.dq[1], 1'b0);
      o.b1[2] = clamp_q30(c.dq[2], !c.sxy[32] && (c.sxy != '0));
    end

    // b1 x d; the first column of hat(d) * [b1 b2] is its negation
    if (s == X1_MUL) begin
      o.xp[0] = smul32(c.b1[1], c.d[2]);
      o.xp[1] = smul32(c.b1[2], c.d[1]);
      o.xp[2] = smul32(c.b1[2], c.d[0]);
      o.xp[3] = smul32(c.b1[0], c.d[2]);
      o.xp[4] = smul32(c.b1[0], c.d[1]);
      o.xp[5] = smul32(c.b1[1], c.d[0]);
    end
    if (s == X1_RND) begin
      for (k = 0; k < 3; k++) begin
        w = rnd30(64'(c.xp[2*k] - c.xp[2*k+1]));
        o.c2[k] = w[32:0];
      end
    end
    if (s == C2_SQ) begin
      for (k = 0; k < 3; k++) begin
        mg = mag33(c.c2[k]);
        o.csq[k] = mg * mg;
      end
    end
    if (s == N2_SUM) begin
      o.sx     = c.csq[0] + c.csq[1] + c.csq[2];
      o.n2zero = (o.sx == '0);
      o.srem   = '0;
      o.sroot  = '0;
    end

    // degenerate second basis contributes nothing
    if (s == B2_OUT) begin
      for (k = 0; k < 3; k++) begin
        o.b2[k] = c.n2zero ? '0 : clamp_q30(c.dq[k], c.c2[k][32]);
      end
    end

    // v = d x b2
    if (s == X2_MUL) begin
      o.xp[0] = smul32(c.d[1], c.b2[2]);
      o.xp[1] = smul32(c.d[2], c.b2[1]);
      o.xp[2] = smul32(c.d[2], c.b2[0]);
      o.xp[3] = smul32(c.d[0], c.b2[2]);
      o.xp[4] = smul32(c.d[0], c.b2[1]);
      o.xp[5] = smul32(c.d[1], c.b2[0]);
    end
    if (s == X2_RND) begin
      for (k = 0; k < 3; k++) begin
        w = rnd30(64'(c.xp[2*k] - c.xp[2*k+1]));
        o.v[k] = w[32:0];
      end
    end

    // per entry: u_i u_j equals c2_i c2_j since u = -c2
    if (s == E_MUL) begin
      for (e = 0; e < 6; e++) begin
        o.pdd[e] = smul32(c.d[PAIR_I[e]], c.d[PAIR_J[e]]);
        o.puu[e] = smul33(c.c2[PAIR_I[e]], c.c2[PAIR_J[e]]);
        o.pvv[e] = smul33(c.v[PAIR_I[e]], c.v[PAIR_J[e]]);
      end
    end
    if (s == E_RND) begin
      for (e = 0; e < 6; e++) begin
        w        = rnd30(c.pdd[e]);
        o.ddr[e] = w[32:0];
        w        = rnd30(c.puu[e]) + rnd30(c.pvv[e]);
        o.wneg[e] = w[34];
        o.wm[e]   = w[34] ? 34'(-w) : w[33:0];
      end
    end

    // range term product and the angle term in three partial products
    if (s == E_PP) begin
      for (e = 0; e < 6; e++) begin
        o.t1p[e] = 64'(smul33({1'b0, rv}, c.ddr[e]));
        o.pp[e][0] = c.rs[26:0] * c.wm[e];
        o.pp[e][1] = c.rs[53:27] * c.wm[e];
        o.pp[e][2] = c.rs[79:54] * c.wm[e];
      end
    end
    if (s == E_SUM) begin
      for (e = 0; e < 6; e++) begin
        t1s = mag64(c.t1p[e]) + 64'h0000_0200_0000_0000;
        t1m = t1s[63:42];
        o.t1[e] = c.t1p[e][63] ? 23'(-{1'b0, t1m}) : {1'b0, t1m};
        o.prod[e] = {53'b0, c.pp[e][0]} + ({53'b0, c.pp[e][1]} << 27) +
                    ({53'b0, c.pp[e][2]} << 54);
      end
    end
    if (s == E_T2) begin
      for (e = 0; e < 6; e++) begin
        tmp = c.prod[e] + (114'd1 << 61);
        t2m = tmp[113:62];
        if (t2m > (52'd1 << 50)) begin
          t2m = 52'd1 << 50;
        end
        o.t2[e] = c.wneg[e] ? 52'(-t2m) : t2m;
      end
    end

    // sum, saturate, zero point gives zero
    if (s == E_OUT) begin
      for (e = 0; e < 6; e++) begin
        tot = {{30{c.t1[e][22]}}, c.t1[e]} + {c.t2[e][51], c.t2[e]};
        if (c.zero) begin
          o.cov[e] = '0;
        end else if (tot > $signed({6'b0, 47'h7FFF_FFFF_FFFF})) begin
          o.cov[e] = 48'h7FFF_FFFF_FFFF;
        end else if (tot < $signed({6'h3F, 47'h0})) begin
          o.cov[e] = 48'h8000_0000_0000;
        end else begin
          o.cov[e] = tot[47:0];
        end
      end
    end
    return o;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_noise      <= RANGE_NOISE_RESET;
      angle_noise_sine <= ANGLE_NOISE_SINE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RANGE_NOISE:      range_noise      <= cfg_data;
        REG_ANGLE_NOISE_SINE: angle_noise_sine <= cfg_data;
        default: ;
      endcase
    end
  end

  // variances follow the registers in the next cycle
  always_ff @(posedge clk) begin
    range_sq  <= range_noise * range_noise;
    angle_var <= angle_noise_sine * angle_noise_sine;
  end

  // the whole pipeline moves unless the skid register holds a result
  assign en       = !skid_v;
  assign in_ready = en;
  assign tail_v   = pipe_v[NUM_STAGES-1];

  always_comb begin
    in_ctx      = '0;
    in_ctx.p[0] = point_x;
    in_ctx.p[1] = point_y;
    in_ctx.p[2] = point_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else if (en) begin
      pipe_v <= {pipe_v[NUM_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= in_ctx;
    end
  end

  for (genvar s = 1; s < NUM_STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        pipe[s] <= stage_work(s, pipe[s-1], range_sq, angle_var);
      end
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        skid_v <= 1'b0;
      end
    end else if (tail_v) begin
      if (!out_v || out_ready) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (out_ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_ready) begin
        out_cov <= skid_cov;
      end
    end else if (tail_v) begin
      if (!out_v || out_ready) begin
        out_cov <= pipe[NUM_STAGES-1].cov;
      end else begin
        skid_cov <= pipe[NUM_STAGES-1].cov;
      end
    end
  end

  assign out_valid = out_v;
  assign cov_xx    = out_cov[0];
  assign cov_xy    = out_cov[1];
  assign cov_xz    = out_cov[2];
  assign cov_yy    = out_cov[3];
  assign cov_yz    = out_cov[4];
  assign cov_zz    = out_cov[5];

  // a parked result always sits behind a shown one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry valid while output register empty");

  // a finished result that meets a stalled output must be parked
  a_tail_parked: assert property (@(posedge clk) disable iff (rst)
    (tail_v && !skid_v && out_v && !out_ready) |=> skid_v)
    else $error("pipeline result lost on output stall");

  // draining the skid entry keeps the output full
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_v && out_ready) |=> (out_v && !skid_v))
    else $error("skid entry not moved to output register");

endmodule : lidar_point_noise_covariance_core
`default_nettype wire
